// ===== rtl/tfp_pkg.sv =====
// Shared constants, band table and payload types for the tuner frequency plan.
// Depends on nothing; imported by tfp_frac and tuner_frequency_plan.
`timescale 1ns / 1ps
`default_nettype none

package tfp_pkg;

    // Crystal and divider constants
    localparam longint unsigned XTAL_HZ = 64'd28800000;
    localparam int XTAL_W = $clog2(XTAL_HZ + 64'd1);
    localparam logic [XTAL_W-1:0] XTAL = XTAL_W'(XTAL_HZ);
    localparam int REM_W = XTAL_W;
    localparam logic [REM_W-1:0] REF_HZ = REM_W'(XTAL_HZ / 2);
    localparam logic [31:0] BIAS = 32'((XTAL_HZ / 2) / 65536);

    // Divide by XTAL as multiply by a truncated reciprocal plus one correction
    localparam int DIV_SHIFT = 40;
    localparam longint unsigned RECIP_L = (64'd1 << DIV_SHIFT) / XTAL_HZ;
    localparam int RECIP_W = $clog2(RECIP_L + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
    localparam int Q_W = $clog2((64'd1 << 32) / XTAL_HZ + 64'd1);
    localparam logic [7:0] INT_OFFSET = 8'd13;

    // VCO window and shift select
    localparam logic [31:0] VCO_LOW = 32'd1770000000;
    localparam logic [31:0] VCO_HIGH = 32'd3900000000;
    localparam int NUM_SHIFTS = 5;
    localparam int SEL_W = 3;
    localparam logic [SEL_W-1:0] SEL_NONE = 3'd5;

    // Band table
    localparam int NUM_BANDS = 21;
    localparam int ROM_ROWS = 21;
    localparam int BAND_COUNT = (NUM_BANDS < ROM_ROWS) ? NUM_BANDS : ROM_ROWS;
    localparam int BAND_W = 5;
    localparam int MHZ_W = 13;
    localparam logic [MHZ_W-1:0] MHZ_MUL = 13'd4295;

    // Fraction
    localparam int SDM_W = 16;
    localparam int FRAC_STAGES = 4;
    localparam int STEPS_PER_STAGE = SDM_W / FRAC_STAGES;

    // Register file
    localparam int APB_AW = 3;
    localparam logic [APB_AW-3:0] REG_IF_OFFSET = '0;
    localparam logic [31:0] IF_OFFSET_RST = 32'd5000000;

    typedef struct packed {
        logic [MHZ_W-1:0] mhz;
        logic             od;
        logic [7:0]       mux;
        logic [7:0]       cap;
    } band_row_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_index;
        logic              open_drain;
        logic [7:0]        rf_mux_poly;
        logic [7:0]        filter_band;
        logic [SEL_W-1:0]  vco_div_sel;
        logic [7:0]        pll_int_byte;
        logic              frac_enable;
    } tfp_side_t;

    function automatic band_row_t band_rom(input logic [BAND_W-1:0] idx);
        band_row_t row;
        case (idx)
            5'd0:    row = '{13'd0,   1'b1, 8'h02, 8'hDF};
            5'd1:    row = '{13'd50,  1'b1, 8'h02, 8'hBE};
            5'd2:    row = '{13'd55,  1'b1, 8'h02, 8'h8B};
            5'd3:    row = '{13'd60,  1'b1, 8'h02, 8'h7B};
            5'd4:    row = '{13'd65,  1'b1, 8'h02, 8'h69};
            5'd5:    row = '{13'd70,  1'b1, 8'h02, 8'h58};
            5'd6:    row = '{13'd75,  1'b0, 8'h02, 8'h44};
            5'd7:    row = '{13'd80,  1'b0, 8'h02, 8'h44};
            5'd8:    row = '{13'd90,  1'b0, 8'h02, 8'h34};
            5'd9:    row = '{13'd100, 1'b0, 8'h02, 8'h34};
            5'd10:   row = '{13'd110, 1'b0, 8'h02, 8'h24};
            5'd11:   row = '{13'd120, 1'b0, 8'h02, 8'h24};
            5'd12:   row = '{13'd140, 1'b0, 8'h02, 8'h14};
            5'd13:   row = '{13'd180, 1'b0, 8'h02, 8'h13};
            5'd14:   row = '{13'd220, 1'b0, 8'h02, 8'h13};
            5'd15:   row = '{13'd250, 1'b0, 8'h02, 8'h11};
            5'd16:   row = '{13'd280, 1'b0, 8'h02, 8'h00};
            5'd17:   row = '{13'd310, 1'b0, 8'h41, 8'h00};
            5'd18:   row = '{13'd450, 1'b0, 8'h41, 8'h00};
            5'd19:   row = '{13'd588, 1'b0, 8'h40, 8'h00};
            5'd20:   row = '{13'd650, 1'b0, 8'h40, 8'h00};
            default: row = '{13'd0,   1'b1, 8'h02, 8'hDF};
        endcase
        return row;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tfp_frac.sv =====
// Greedy sigma-delta fraction: sixteen compare-subtract steps over four stages.
// Depends on tfp_pkg; instantiated by tuner_frequency_plan. Last stage is the output register.
`timescale 1ns / 1ps
`default_nettype none

module tfp_frac (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [tfp_pkg::REM_W-1:0]   in_rem,
    input  wire tfp_pkg::tfp_side_t          in_side,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [tfp_pkg::SDM_W-1:0]        out_sdm,
    output tfp_pkg::tfp_side_t               out_side
);
    import tfp_pkg::*;

    logic [FRAC_STAGES-1:0] v_reg;
    logic [FRAC_STAGES-1:0] v_src;
    logic [FRAC_STAGES-1:0] rdy;
    logic [REM_W-1:0]       rem_reg  [FRAC_STAGES];
    logic [REM_W-1:0]       rem_src  [FRAC_STAGES];
    logic [REM_W-1:0]       rem_next [FRAC_STAGES];
    logic [SDM_W-1:0]       sdm_reg  [FRAC_STAGES];
    logic [SDM_W-1:0]       sdm_src  [FRAC_STAGES];
    logic [SDM_W-1:0]       sdm_next [FRAC_STAGES];
    tfp_side_t              side_reg [FRAC_STAGES];
    tfp_side_t              side_src [FRAC_STAGES];

    // A stage takes a new request when empty or when the one ahead moves on
    always_comb begin
        rdy[FRAC_STAGES-1] = !v_reg[FRAC_STAGES-1] || out_ready;
        for (int j = FRAC_STAGES - 2; j >= 0; j--) begin
            rdy[j] = !v_reg[j] || rdy[j+1];
        end
    end

    always_comb begin
        v_src[0]    = in_valid;
        rem_src[0]  = in_rem;
        sdm_src[0]  = '0;
        side_src[0] = in_side;
        for (int j = 1; j < FRAC_STAGES; j++) begin
            v_src[j]    = v_reg[j-1];
            rem_src[j]  = rem_reg[j-1];
            sdm_src[j]  = sdm_reg[j-1];
            side_src[j] = side_reg[j-1];
        end
    end

    // Subtract each weight that still fits, heaviest first
    always_comb begin
        for (int j = 0; j < FRAC_STAGES; j++) begin
            rem_next[j] = rem_src[j];
            sdm_next[j] = sdm_src[j];
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                if (rem_next[j] >= (REF_HZ >> (j * STEPS_PER_STAGE + s))) begin
                    rem_next[j] = rem_next[j] - (REF_HZ >> (j * STEPS_PER_STAGE + s));
                    sdm_next[j][SDM_W-1-(j*STEPS_PER_STAGE+s)] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int j = 0; j < FRAC_STAGES; j++) begin
                if (rdy[j]) begin
                    v_reg[j] <= v_src[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < FRAC_STAGES; j++) begin
            if (rdy[j]) begin
                rem_reg[j]  <= rem_next[j];
                sdm_reg[j]  <= sdm_next[j];
                side_reg[j] <= side_src[j];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[FRAC_STAGES-1];
    assign out_sdm   = sdm_reg[FRAC_STAGES-1];
    assign out_side  = side_reg[FRAC_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/tuner_frequency_plan.sv =====
// Tuner frequency plan top level: register port, band, VCO, integer divider stages.
// Depends on tfp_pkg and tfp_frac.
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+-----------------------------
//   input    | s_valid s_ready s_rf_freq          | one RF frequency request
//   result   | m_valid m_ready m_* fields         | one settings word per request
//   register | psel penable pwrite paddr pwdata.. | if_offset at byte address 0
//
// One request enters per cycle while no stage is stalled; its result passes through
// five stages for band, VCO and the reciprocal divide, then four for the 16-step fraction.
// aresetn is synchronous: it empties the pipeline and loads if_offset with 5000000.
// Each stage holds while the stage ahead is full and stalled; empty stages still fill,
// so requests are taken while a result waits, until every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none

module tuner_frequency_plan (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [tfp_pkg::APB_AW-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // request channel
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [31:0]                  s_rf_freq,
    // result channel
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tfp_pkg::BAND_W-1:0]        m_band_index,
    output logic                              m_open_drain,
    output logic [7:0]                        m_rf_mux_poly,
    output logic [7:0]                        m_filter_band,
    output logic [tfp_pkg::SEL_W-1:0]         m_vco_div_sel,
    output logic [7:0]                        m_pll_int_byte,
    output logic [tfp_pkg::SDM_W-1:0]         m_sdm_word,
    output logic                              m_frac_enable
);
    import tfp_pkg::*;

    logic [31:0] if_offset_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic frac_ready;

    // stage 1
    logic [31+MHZ_W:0]       mhz_prod;
    logic [MHZ_W-1:0]        mhz1_reg;
    logic [31:0]             lo1_reg;
    // stage 2
    logic [BAND_W-1:0]       band2_next, band2_reg;
    logic [SEL_W-1:0]        sel2_next, sel2_reg;
    logic [31:0]             vco2, vco_cand;
    logic [31:0]             x2_reg;
    // stage 3
    logic [31+RECIP_W:0]     recip_prod;
    band_row_t               row3;
    tfp_side_t               side3_next, side3_reg;
    logic [31:0]             x3_reg;
    logic [Q_W-1:0]          qe3_reg;
    // stage 4
    logic [Q_W+XTAL_W-1:0]   p_prod;
    logic [31:0]             p4_reg, x4_reg;
    logic [Q_W-1:0]          qe4_reg;
    tfp_side_t               side4_reg;
    // stage 5
    logic [31:0]             r_full, r_fix;
    logic [Q_W-1:0]          q5;
    logic [7:0]              n5;
    logic [REM_W-1:0]        r5_reg;
    tfp_side_t               side5_next, side5_reg;
    // fraction output
    logic [SDM_W-1:0]        frac_sdm;
    tfp_side_t               out_side;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == REG_IF_OFFSET) ? if_offset_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            if_offset_reg <= IF_OFFSET_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[APB_AW-1:2] == REG_IF_OFFSET) begin
                if_offset_reg <= pwdata;
            end
        end
    end

    // Stall chain
    assign rdy5    = !v5_reg || frac_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: MHz estimate and LO sum
    assign mhz_prod = (32 + MHZ_W)'(s_rf_freq) * (32 + MHZ_W)'(MHZ_MUL);

    // Stage 2: band scan and VCO shift select; the lowest fitting shift wins
    always_comb begin
        band2_next = BAND_W'(BAND_COUNT - 1);
        for (int i = BAND_COUNT - 1; i >= 1; i--) begin
            if (mhz1_reg < band_rom(BAND_W'(i)).mhz) begin
                band2_next = BAND_W'(i - 1);
            end
        end
    end

    always_comb begin
        vco_cand  = '0;
        sel2_next = SEL_NONE;
        vco2      = lo1_reg << (NUM_SHIFTS + 1);
        for (int k = NUM_SHIFTS - 1; k >= 0; k--) begin
            vco_cand = lo1_reg << (k + 1);
            if (vco_cand >= VCO_LOW && vco_cand <= VCO_HIGH) begin
                sel2_next = SEL_W'(k);
                vco2      = vco_cand;
            end
        end
    end

    // Stage 3: quotient estimate and table row
    assign recip_prod = (32 + RECIP_W)'(x2_reg) * (32 + RECIP_W)'(RECIP);
    assign row3       = band_rom(band2_reg);

    always_comb begin
        side3_next              = '0;
        side3_next.band_index   = band2_reg;
        side3_next.open_drain   = row3.od;
        side3_next.rf_mux_poly  = row3.mux;
        side3_next.filter_band  = row3.cap;
        side3_next.vco_div_sel  = sel2_reg;
    end

    // Stage 4: product of estimate and crystal
    assign p_prod = (Q_W + XTAL_W)'(qe3_reg) * (Q_W + XTAL_W)'(XTAL);

    // Stage 5: correct the estimate once; remainder is below the crystal after it
    always_comb begin
        r_full = x4_reg - p4_reg;
        if (r_full >= 32'(XTAL)) begin
            r_fix = r_full - 32'(XTAL);
            q5    = qe4_reg + Q_W'(1);
        end else begin
            r_fix = r_full;
            q5    = qe4_reg;
        end
        n5                       = 8'(q5) - INT_OFFSET;
        side5_next               = side4_reg;
        side5_next.pll_int_byte  = {n5[1:0], n5[7:2]};
        side5_next.frac_enable   = (r_fix != BIAS);
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            mhz1_reg <= mhz_prod[32 +: MHZ_W];
            lo1_reg  <= s_rf_freq + if_offset_reg;
        end
        if (rdy2) begin
            band2_reg <= band2_next;
            sel2_reg  <= sel2_next;
            x2_reg    <= vco2 + BIAS;
        end
        if (rdy3) begin
            side3_reg <= side3_next;
            x3_reg    <= x2_reg;
            qe3_reg   <= recip_prod[DIV_SHIFT +: Q_W];
        end
        if (rdy4) begin
            side4_reg <= side3_reg;
            x4_reg    <= x3_reg;
            qe4_reg   <= qe3_reg;
            p4_reg    <= 32'(p_prod);
        end
        if (rdy5) begin
            side5_reg <= side5_next;
            r5_reg    <= REM_W'(r_fix);
        end
    end

    tfp_frac u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v5_reg),
        .in_ready  (frac_ready),
        .in_rem    (r5_reg),
        .in_side   (side5_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_sdm   (frac_sdm),
        .out_side  (out_side)
    );

    assign m_band_index   = out_side.band_index;
    assign m_open_drain   = out_side.open_drain;
    assign m_rf_mux_poly  = out_side.rf_mux_poly;
    assign m_filter_band  = out_side.filter_band;
    assign m_vco_div_sel  = out_side.vco_div_sel;
    assign m_pll_int_byte = out_side.pll_int_byte;
    assign m_frac_enable  = out_side.frac_enable;
    // drop the fraction when the remainder is exact
    assign m_sdm_word     = out_side.frac_enable ? frac_sdm : '0;

`ifndef SYNTHESIS
    a_rem_corrected: assert property (@(posedge aclk) disable iff (!aresetn)
        v5_reg |-> (r5_reg < REM_W'(XTAL)))
        else $error("remainder not below crystal after correction");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_band_index <= BAND_W'(BAND_COUNT - 1)) && (m_vco_div_sel <= SEL_NONE))
        else $error("band or VCO select out of range");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && m_valid)
        else $error("request refused while a stage is empty");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted request not held in first stage");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for tuner_frequency_plan: directed table, then random requests.
// Depends on tfp_pkg and the RTL under rtl/; expected settings come from a local predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int          BAND_ROWS    = 21;
    localparam logic [31:0] CRYSTAL_HZ   = 32'd28800000;
    localparam logic [31:0] REF_HALF     = CRYSTAL_HZ >> 1;
    localparam logic [31:0] SDM_BIAS     = REF_HALF >> 16;
    localparam logic [31:0] VCO_MIN      = 32'd1770000000;
    localparam logic [31:0] VCO_MAX      = 32'd3900000000;
    localparam logic [63:0] MHZ_SCALE    = 64'd4295;
    localparam logic [7:0]  N_OFFSET     = 8'd13;
    localparam logic [2:0]  NO_FIT_SEL   = 3'd5;
    localparam logic [31:0] IF_DEFAULT   = 32'd5000000;

    localparam logic [tfp_pkg::APB_AW-1:0] IF_OFFSET_ADDR = 3'd0;
    localparam logic [tfp_pkg::APB_AW-1:0] SPARE_ADDR     = 3'd4;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 72;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic [9:0] mhz;
        logic       od;
        logic [7:0] mux;
        logic [7:0] cap;
    } band_t;

    typedef struct packed {
        logic [tfp_pkg::BAND_W-1:0] band_index;
        logic                       open_drain;
        logic [7:0]                 rf_mux_poly;
        logic [7:0]                 filter_band;
        logic [tfp_pkg::SEL_W-1:0]  vco_div_sel;
        logic [7:0]                 pll_int_byte;
        logic [tfp_pkg::SDM_W-1:0]  sdm_word;
        logic                       frac_enable;
    } plan_t;

    typedef struct packed {
        logic        wr_cfg;
        logic [31:0] cfg;
        logic [31:0] rf;
        logic        typed;
        plan_t       want;
    } dir_row_t;

    localparam plan_t NO_PLAN = '0;

    band_t band_table [0:BAND_ROWS-1] = '{
        '{10'd0,   1'b1, 8'h02, 8'hDF}, '{10'd50,  1'b1, 8'h02, 8'hBE},
        '{10'd55,  1'b1, 8'h02, 8'h8B}, '{10'd60,  1'b1, 8'h02, 8'h7B},
        '{10'd65,  1'b1, 8'h02, 8'h69}, '{10'd70,  1'b1, 8'h02, 8'h58},
        '{10'd75,  1'b0, 8'h02, 8'h44}, '{10'd80,  1'b0, 8'h02, 8'h44},
        '{10'd90,  1'b0, 8'h02, 8'h34}, '{10'd100, 1'b0, 8'h02, 8'h34},
        '{10'd110, 1'b0, 8'h02, 8'h24}, '{10'd120, 1'b0, 8'h02, 8'h24},
        '{10'd140, 1'b0, 8'h02, 8'h14}, '{10'd180, 1'b0, 8'h02, 8'h13},
        '{10'd220, 1'b0, 8'h02, 8'h13}, '{10'd250, 1'b0, 8'h02, 8'h11},
        '{10'd280, 1'b0, 8'h02, 8'h00}, '{10'd310, 1'b0, 8'h41, 8'h00},
        '{10'd450, 1'b0, 8'h41, 8'h00}, '{10'd588, 1'b0, 8'h40, 8'h00},
        '{10'd650, 1'b0, 8'h40, 8'h00}
    };

    // Typed expectations: reset IF with no VCO fit, LO wrap, exact integer VCO,
    // and an IF of all ones that brings the LO to zero.
    dir_row_t dir_table [0:DIR_ROWS-1] = '{
        '{1'b0, 32'd0, 32'd0, 1'b1,
          '{5'd0, 1'b1, 8'h02, 8'hDF, NO_FIT_SEL, 8'hBF, 16'h1C72, 1'b1}},
        '{1'b0, 32'd0, 32'hFFFFFFFF, 1'b1,
          '{5'd20, 1'b0, 8'h40, 8'h00, NO_FIT_SEL, 8'hBF, 16'h1C72, 1'b1}},
        '{1'b0, 32'd0, 32'd1000000000, 1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd600000000,  1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd300000000,  1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd150000000,  1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd80000000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd49999000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd50000000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd74900000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd75000000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd650000000,  1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd1795000000, 1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'd24000000,   1'b0, NO_PLAN},
        '{1'b1, 32'd0, 32'd1800000000, 1'b1,
          '{5'd20, 1'b0, 8'h40, 8'h00, 3'd0, 8'h1C, 16'h0000, 1'b0}},
        '{1'b0, 32'd0, 32'd1799999950, 1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'hFFFFFFFF,   1'b0, NO_PLAN},
        '{1'b1, 32'hFFFFFFFF, 32'd1, 1'b1,
          '{5'd0, 1'b1, 8'h02, 8'hDF, NO_FIT_SEL, 8'hFC, 16'h0000, 1'b0}},
        '{1'b0, 32'd0, 32'd0,          1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'h80000000,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'h55555555,   1'b0, NO_PLAN},
        '{1'b0, 32'd0, 32'hAAAAAAAA,   1'b0, NO_PLAN},
        '{1'b1, IF_DEFAULT, 32'd433920000, 1'b0, NO_PLAN}
    };

    logic                        aclk;
    logic                        aresetn;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tfp_pkg::APB_AW-1:0]  paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        s_valid;
    logic                        s_ready;
    logic [31:0]                 s_rf_freq;
    logic                        m_valid;
    logic                        m_ready;
    logic [tfp_pkg::BAND_W-1:0]  m_band_index;
    logic                        m_open_drain;
    logic [7:0]                  m_rf_mux_poly;
    logic [7:0]                  m_filter_band;
    logic [tfp_pkg::SEL_W-1:0]   m_vco_div_sel;
    logic [7:0]                  m_pll_int_byte;
    logic [tfp_pkg::SDM_W-1:0]   m_sdm_word;
    logic                        m_frac_enable;

    plan_t       pending_plans [$];
    logic [31:0] if_shadow;
    int          errors;
    int          cycles;
    bit          src_idle_on;
    bit          snk_idle_on;

    tuner_frequency_plan dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rf_freq      (s_rf_freq),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_band_index   (m_band_index),
        .m_open_drain   (m_open_drain),
        .m_rf_mux_poly  (m_rf_mux_poly),
        .m_filter_band  (m_filter_band),
        .m_vco_div_sel  (m_vco_div_sel),
        .m_pll_int_byte (m_pll_int_byte),
        .m_sdm_word     (m_sdm_word),
        .m_frac_enable  (m_frac_enable)
    );

    always #4 aclk = ~aclk;

    // Settings word for one RF request at the given IF offset.
    function automatic plan_t tune_plan(input logic [31:0] rf, input logic [31:0] ifo);
        plan_t       p;
        logic [63:0] prod;
        logic [31:0] mhz;
        logic [31:0] lo;
        logic [31:0] vco;
        logic [31:0] quo;
        logic [31:0] rem;
        logic [31:0] w;
        logic [7:0]  n;
        logic [2:0]  sel;
        int          band;
        p = '0;
        prod = {32'd0, rf} * MHZ_SCALE;
        mhz = prod[63:32];
        band = 0;
        for (int r = 1; r < BAND_ROWS; r++)
            if (mhz >= {22'd0, band_table[r].mhz}) band = r;
        p.band_index  = band[tfp_pkg::BAND_W-1:0];
        p.open_drain  = band_table[band].od;
        p.rf_mux_poly = band_table[band].mux;
        p.filter_band = band_table[band].cap;

        // walk down so the smallest fitting shift wins
        lo = rf + ifo;
        sel = NO_FIT_SEL;
        for (int s = 5; s >= 1; s--) begin
            vco = lo << s;
            if (vco >= VCO_MIN && vco <= VCO_MAX) sel = 3'(s - 1);
        end
        vco = lo << (sel + 1);
        p.vco_div_sel = sel;

        quo = (vco + SDM_BIAS) / CRYSTAL_HZ;
        n = quo[7:0];
        rem = vco - CRYSTAL_HZ * {24'd0, n};
        n = n - N_OFFSET;
        p.pll_int_byte = {n[1:0], n[7:2]};

        if (rem != 32'd0) begin
            p.frac_enable = 1'b1;
            rem = rem + SDM_BIAS;
            for (int k = 0; k < 16; k++) begin
                w = REF_HALF >> k;
                if (rem >= w) begin
                    p.sdm_word[15-k] = 1'b1;
                    rem = rem - w;
                end
            end
        end
        return p;
    endfunction

    // Random RF request, weighted towards band edges, exact VCO multiples and window edges.
    function automatic logic [31:0] pick_freq(input logic [31:0] ifo);
        logic [63:0] cut;
        logic [31:0] target;
        logic [31:0] delta;
        logic [31:0] rf;
        int unsigned row;
        int unsigned shift;
        int unsigned mult;
        delta = $urandom_range(0, 4) - 2;
        shift = $urandom_range(1, 5);
        case ($urandom_range(0, 5))
            0: rf = $urandom;
            1: rf = $urandom_range(24000000, 1766000000);
            2: begin
                row = $urandom_range(1, BAND_ROWS - 1);
                cut = (({54'd0, band_table[row].mhz} << 32) + 64'd4294) / MHZ_SCALE;
                rf = cut[31:0] + delta;
            end
            3: begin
                mult = $urandom_range(62, 135);
                target = mult * CRYSTAL_HZ;
                rf = (target >> shift) - ifo + delta;
            end
            4: rf = $urandom_range(0, 100000000);
            default: begin
                target = $urandom_range(0, 1) ? VCO_MIN : VCO_MAX;
                rf = (target >> shift) - ifo + delta;
            end
        endcase
        return rf;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    task automatic apb_write(input logic [tfp_pkg::APB_AW-1:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [tfp_pkg::APB_AW-1:0] addr,
                                  input logic [31:0] want);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("if_offset", want, prdata);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold requests until the pipe is empty, then move the IF offset.
    task automatic retune_if(input logic [31:0] value);
        s_valid <= 1'b0;
        while (pending_plans.size() != 0) @(posedge aclk);
        apb_write(IF_OFFSET_ADDR, value);
        if_shadow = value;
        // unmapped register: must leave if_offset alone
        apb_write(SPARE_ADDR, ~value);
        apb_read_check(IF_OFFSET_ADDR, if_shadow);
    endtask

    task automatic request_freq(input logic [31:0] rf, input plan_t want);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_rf_freq <= rf;
        do @(posedge aclk); while (!s_ready);
        pending_plans.push_back(want);
    endtask

    // Result side: random stalls, with stretches of none.
    initial begin : sink
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = snk_idle_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : score
        plan_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_plans.size() == 0) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                want = pending_plans.pop_front();
                check_field("band_index",   want.band_index,   m_band_index);
                check_field("open_drain",   want.open_drain,   m_open_drain);
                check_field("rf_mux_poly",  want.rf_mux_poly,  m_rf_mux_poly);
                check_field("filter_band",  want.filter_band,  m_filter_band);
                check_field("vco_div_sel",  want.vco_div_sel,  m_vco_div_sel);
                check_field("pll_int_byte", want.pll_int_byte, m_pll_int_byte);
                check_field("sdm_word",     want.sdm_word,     m_sdm_word);
                check_field("frac_enable",  want.frac_enable,  m_frac_enable);
            end
        end
    end

    initial begin : stimulus
        logic [31:0] rf;
        logic [31:0] ifo;
        aclk = 1'b0;
        aresetn = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        s_valid = 1'b0;
        s_rf_freq = '0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        if_shadow = IF_DEFAULT;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        apb_read_check(IF_OFFSET_ADDR, IF_DEFAULT);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_table[i].wr_cfg) retune_if(dir_table[i].cfg);
            request_freq(dir_table[i].rf, dir_table[i].typed ? dir_table[i].want
                                                              : tune_plan(dir_table[i].rf,
                                                                          if_shadow));
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: ifo = 32'd0;
                1: ifo = 32'hFFFFFFFF;
                2: ifo = $urandom_range(3000000, 60000000);
                3: ifo = $urandom;
                4: ifo = 32'd36000000;
                default: ifo = IF_DEFAULT;
            endcase
            retune_if(ifo);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 24 == 0) begin
                    src_idle_on = ($urandom_range(0, 3) != 0);
                    snk_idle_on = ($urandom_range(0, 3) != 0);
                end
                rf = pick_freq(if_shadow);
                request_freq(rf, tune_plan(rf, if_shadow));
            end
        end

        s_valid <= 1'b0;
        while (pending_plans.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
